@@ src/bos_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bos_pkg
// Shared types, widths and helpers for the bit-vector overlap similarity block.
// ----------------------------------------------------------------------------
package bos_pkg;

    localparam int WORD_W    = 64;
    localparam int CNT_W     = 17;              // counts up to 1024 words * 64 bits
    localparam int SUM_W     = CNT_W + 1;       // count_a + count_b
    localparam int SCORE_W   = 16;
    localparam int PC_W      = 7;               // popcount of one 64-bit word
    localparam int DIV_STEPS = SCORE_W;         // one quotient bit per step
    localparam int QDEPTH    = 2;

    // one request: a word pair of the two rows
    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic              last_word;
    } t_req;

    // one result, issued on the last word pair
    typedef struct packed {
        logic [CNT_W-1:0]   overlap;
        logic [SCORE_W-1:0] score_q16;
        logic               empty_row;
    } t_rsp;

    // finished row totals handed from the accumulator to the divider
    typedef struct packed {
        logic [CNT_W-1:0] overlap;
        logic [SUM_W-1:0] sum;
        logic             empty_row;
    } t_job;

    // popcount of a 64-bit word: per-byte counts, then a sum of eight bytes
    function automatic logic [PC_W-1:0] pop64(input logic [WORD_W-1:0] v);
        logic [3:0]      byte_cnt [8];
        logic [PC_W-1:0] total;
        for (int i = 0; i < 8; i++) begin
            byte_cnt[i] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[i] = byte_cnt[i] + {3'b000, v[i*8+j]};
            end
        end
        total = '0;
        for (int i = 0; i < 8; i++) begin
            total = total + {3'b000, byte_cnt[i]};
        end
        return total;
    endfunction

endpackage

@@ src/bos_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bos_front
// Takes word pairs, counts their set bits and keeps the three saturating row
// counts. On the last pair it pushes the row totals into the queue and clears.
// ----------------------------------------------------------------------------
module bos_front #(
    parameter int MAX_WORDS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bos_pkg::t_req i_req,
    output logic          o_push,
    output bos_pkg::t_job o_job,
    input  logic          i_full
);
    import bos_pkg::*;

    localparam logic [SUM_W-1:0] BIT_LIMIT = SUM_W'(MAX_WORDS * WORD_W);

    // popcount stage
    logic            r_s1_valid;
    logic            r_s1_last;
    logic [PC_W-1:0] r_pc_ab;
    logic [PC_W-1:0] r_pc_a;
    logic [PC_W-1:0] r_pc_b;

    // running counts
    logic [CNT_W-1:0] r_ov;
    logic [CNT_W-1:0] r_ca;
    logic [CNT_W-1:0] r_cb;
    logic [CNT_W-1:0] n_ov;
    logic [CNT_W-1:0] n_ca;
    logic [CNT_W-1:0] n_cb;

    logic             accept;
    logic             advance;
    logic [SUM_W-1:0] sum_ov;
    logic [SUM_W-1:0] sum_ca;
    logic [SUM_W-1:0] sum_cb;

    // a last pair waits here while the queue is full
    assign advance = r_s1_valid && (!r_s1_last || !i_full);
    assign o_stall = r_s1_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_req.last_word;
            r_pc_ab   <= pop64(i_req.word_a & i_req.word_b);
            r_pc_a    <= pop64(i_req.word_a);
            r_pc_b    <= pop64(i_req.word_b);
        end
    end

    // saturating accumulate
    always_comb begin
        sum_ov = {1'b0, r_ov} + SUM_W'(r_pc_ab);
        sum_ca = {1'b0, r_ca} + SUM_W'(r_pc_a);
        sum_cb = {1'b0, r_cb} + SUM_W'(r_pc_b);
        n_ov   = (sum_ov > BIT_LIMIT) ? BIT_LIMIT[CNT_W-1:0] : sum_ov[CNT_W-1:0];
        n_ca   = (sum_ca > BIT_LIMIT) ? BIT_LIMIT[CNT_W-1:0] : sum_ca[CNT_W-1:0];
        n_cb   = (sum_cb > BIT_LIMIT) ? BIT_LIMIT[CNT_W-1:0] : sum_cb[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= '0;
            r_ca <= '0;
            r_cb <= '0;
        end else if (advance) begin
            if (r_s1_last) begin
                r_ov <= '0;
                r_ca <= '0;
                r_cb <= '0;
            end else begin
                r_ov <= n_ov;
                r_ca <= n_ca;
                r_cb <= n_cb;
            end
        end
    end

    // row totals toward the divider
    assign o_push          = advance && r_s1_last;
    assign o_job.overlap   = n_ov;
    assign o_job.sum       = {1'b0, n_ca} + {1'b0, n_cb};
    assign o_job.empty_row = (n_ca == '0) || (n_cb == '0);

`ifndef SYNTHESIS
    a_ov_le_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov <= r_ca) else $error("overlap count exceeds count of row A");
    a_ov_le_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov <= r_cb) else $error("overlap count exceeds count of row B");
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ca} <= BIT_LIMIT) && ({1'b0, r_cb} <= BIT_LIMIT))
        else $error("row count above saturation limit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_ov == '0) && (r_ca == '0) && (r_cb == '0))
        else $error("counts not cleared after last pair");
`endif

endmodule

@@ src/bos_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bos_queue
// Short queue of row totals between the accumulator and the divider.
// ----------------------------------------------------------------------------
module bos_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bos_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output bos_pkg::t_job o_job
);
    import bos_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_job              r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_QW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ src/bos_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bos_back
// Turns row totals into a result: restoring division overlap * 2^16 / sum,
// one quotient bit per cycle, then an output register toward the consumer.
// ----------------------------------------------------------------------------
module bos_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bos_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output bos_pkg::t_rsp o_rsp
);
    import bos_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_div;
    logic [SCORE_W-1:0] r_quo;
    logic [CNT_W-1:0]   r_ov;
    logic               r_empty;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               out_free;
    logic [SUM_W:0]     rem2;
    logic               q_bit;
    logic [SUM_W-1:0]   n_rem;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    // one restoring step: shift, compare, subtract
    always_comb begin
        rem2  = {r_rem, 1'b0};
        q_bit = (rem2 >= {1'b0, r_div});
        n_rem = q_bit ? SUM_W'(rem2 - {1'b0, r_div}) : rem2[SUM_W-1:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_step  <= '0;
                        r_state <= i_job.empty_row ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem   <= SUM_W'(i_job.overlap);
            r_div   <= i_job.sum;
            r_quo   <= '0;
            r_ov    <= i_job.overlap;
            r_empty <= i_job.empty_row;
        end else if (r_state == ST_DIV) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SCORE_W-2:0], q_bit};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.overlap   <= r_ov;
            r_out.score_q16 <= r_empty ? '0 : r_quo;
            r_out.empty_row <= r_empty;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_step != STEP_W'(DIV_STEPS - 1))
        |=> (r_state == ST_DIV) && (r_step == $past(r_step) + 1'b1))
        else $error("divider step count broken");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
    a_score_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.score_q16 <= SCORE_W'(32768)))
        else $error("score above one half");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.empty_row) |-> (o_rsp.score_q16 == '0))
        else $error("empty row with nonzero score");
`endif

endmodule

@@ src/bitvector_overlap_similarity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitvector_overlap_similarity
// Half-Dice overlap score of two binary rows streamed as 64-bit word pairs.
// ----------------------------------------------------------------------------
// Throughput: one word pair per cycle; the popcount accumulator never waits
//   unless a last pair meets a full two-entry result queue.
// Result path: a last pair passes the popcount register, the result queue, the
//   16-step restoring divider (one quotient bit per cycle) and the output register.
// Rows found empty skip the divider steps and go straight to the done state.
// Reset: synchronous, clears the running counts, queue and divider control.
module bitvector_overlap_similarity #(
    parameter int MAX_WORDS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bos_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output bos_pkg::t_rsp o_rsp
);
    import bos_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job job_in;
    t_job job_out;

    // accumulate popcounts
    bos_front #(
        .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    // row totals waiting for the divider
    bos_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // division and output register
    bos_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule
